/* rtl/slls_pkg.sv */
`timescale 1ns / 1ps

package slls_pkg;

    // Pool size default and dump bound
    localparam int SLOTS_DEFAULT = 16;
    localparam int DUMP_LIMIT    = 16;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_FREE,
        S_INS_WALK,
        S_INS_FIX,
        S_DUMP,
        S_RESP
    } state_t;

endpackage

/* rtl/sorted_linked_list_store_core.sv */
`timescale 1ns / 1ps

// Sorted linked list store.
// Item channel (item_valid / item_stall, opcode, item_value) takes one
// transaction at a time: insert a signed value, dump the list, or clear it.
// Result channel (result_valid / result_stall, out_value, status, last_flag)
// returns one result for insert and clear, and for a dump one result per list
// entry (at most 16) or a single empty result, the final one marked by last_flag.
// Values and links live in two single-port-read RAMs with a registered read
// port; every list step is one RAM read.
// A full insert, an empty dump or a clear goes straight to the response
// state; an insert pops a free slot and, unless the list is empty, walks it
// reading one entry per step, then fixes the predecessor's link in a further
// state when linked behind an existing entry; a dump gives one value per
// cycle while the result is not stalled.
// A new transaction is taken only when the sequencer is idle, even while the
// previous result still waits in the output register.
// A stalled result holds in the output register and the sequencer waits for
// it; a dump resumes where it stopped.
// Reset (and the clear opcode) empties the list and rechains every slot onto
// the free list at once through per-slot link valid bits; no sweep is needed.
module sorted_linked_list_store_core
    import slls_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [OP_W-1:0]            opcode,
    input  logic signed [VALUE_W-1:0]  item_value,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [VALUE_W-1:0]  out_value,
    output logic [STATUS_W-1:0]        status,
    output logic                       last_flag
);

    localparam int AW       = $clog2(SLOTS);
    localparam int LW       = $clog2(SLOTS + 1);
    localparam int DUMP_MAX = (DUMP_LIMIT < SLOTS) ? DUMP_LIMIT : SLOTS;
    localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);
    localparam logic [LW-1:0] LAST_STEP = LW'(SLOTS - 1);
    localparam logic [LW-1:0] DUMP_LAST = LW'(DUMP_MAX - 1);

    // Sequencer and list registers
    state_t                     state_reg, state_next;
    logic [LW-1:0]              head_reg, head_next;
    logic [LW-1:0]              free_reg, free_next;
    logic [LW-1:0]              fresh_reg, fresh_next;
    logic [LW-1:0]              cur_reg, cur_next;
    logic [LW-1:0]              prev_reg, prev_next;
    logic [LW-1:0]              cnt_reg, cnt_next;
    logic [VALUE_W-1:0]         key_reg, key_next;
    logic [STATUS_W-1:0]        pend_reg, pend_next;
    logic [SLOTS-1:0]           lvalid_reg, lvalid_next;
    logic [AW-1:0]              raddr_reg;

    // Output register
    logic                       result_valid_reg, result_valid_next;
    logic [VALUE_W-1:0]         out_value_reg, out_value_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic                       last_reg, last_next;

    // RAM ports
    logic                       val_we;
    logic [AW-1:0]              val_waddr;
    logic [VALUE_W-1:0]         val_rdata;
    logic                       link_we;
    logic [AW-1:0]              link_waddr;
    logic [LW-1:0]              link_wdata;
    logic [LW-1:0]              link_rdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;

    logic [LW-1:0]              rd_link;
    logic                       rd_link_null;
    logic                       head_null;
    logic                       free_null;
    logic                       item_accept;
    logic                       out_free;
    logic                       result_load;
    logic                       advance;
    logic                       ins_done;
    logic [LW-1:0]              cur_final;
    logic [LW-1:0]              prev_final;

    slls_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (key_next),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (val_rdata)
    );

    slls_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (link_rdata)
    );

    // Unwritten link reads as its reset chain value i+1
    assign rd_link      = lvalid_reg[raddr_reg] ? link_rdata : (LW'(raddr_reg) + LW'(1));
    assign rd_link_null = (rd_link >= NULL_LINK);
    assign head_null    = (head_reg >= NULL_LINK);
    assign free_null    = (free_reg >= NULL_LINK);

    assign item_stall   = (state_reg != S_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;

    // Walk step: move on while the stored value is smaller than the key
    assign advance    = ($signed(val_rdata) < $signed(key_reg));
    assign cur_final  = advance ? rd_link : cur_reg;
    assign prev_final = advance ? cur_reg : prev_reg;

    // Sequencer next state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        free_next    = free_reg;
        fresh_next   = fresh_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        cnt_next     = cnt_reg;
        key_next     = key_reg;
        pend_next    = pend_reg;
        lvalid_next  = lvalid_reg;
        val_we       = 1'b0;
        val_waddr    = free_reg[AW-1:0];
        link_we      = 1'b0;
        link_waddr   = fresh_reg[AW-1:0];
        link_wdata   = NULL_LINK;
        ram_re       = 1'b0;
        ram_raddr    = head_reg[AW-1:0];
        result_load  = 1'b0;
        out_value_next = '0;
        status_next  = pend_reg;
        last_next    = 1'b1;
        ins_done     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    key_next = item_value;
                    case (opcode)
                        OP_INSERT:
                        begin
                            if (free_null)
                            begin
                                pend_next  = ST_FULL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                // Pop the free slot and store the value there
                                fresh_next = free_reg;
                                val_we     = 1'b1;
                                val_waddr  = free_reg[AW-1:0];
                                ram_re     = 1'b1;
                                ram_raddr  = free_reg[AW-1:0];
                                state_next = S_INS_FREE;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (head_null)
                            begin
                                pend_next  = ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg[AW-1:0];
                                cnt_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            head_next   = NULL_LINK;
                            free_next   = '0;
                            lvalid_next = '0;
                            pend_next   = ST_CLEARED;
                            state_next  = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_FREE:
            begin
                // Advance the free list, then start the walk at the head
                free_next = rd_link;
                prev_next = NULL_LINK;
                cnt_next  = '0;
                if (head_null)
                begin
                    link_we    = 1'b1;
                    link_waddr = fresh_reg[AW-1:0];
                    link_wdata = NULL_LINK;
                    head_next  = fresh_reg;
                    pend_next  = ST_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    cur_next   = head_reg;
                    ram_re     = 1'b1;
                    ram_raddr  = head_reg[AW-1:0];
                    state_next = S_INS_WALK;
                end
            end

            S_INS_WALK:
            begin
                if (advance && !rd_link_null && (cnt_reg != LAST_STEP))
                begin
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                    cnt_next  = cnt_reg + LW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = rd_link[AW-1:0];
                end
                else
                begin
                    ins_done   = 1'b1;
                    prev_next  = prev_final;
                    cur_next   = cur_final;
                    link_we    = 1'b1;
                    link_waddr = fresh_reg[AW-1:0];
                    link_wdata = (cur_final >= NULL_LINK) ? NULL_LINK : cur_final;
                    pend_next  = ST_OK;
                    if (prev_final >= NULL_LINK)
                    begin
                        head_next  = fresh_reg;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_INS_FIX;
                    end
                end
            end

            S_INS_FIX:
            begin
                // Link the predecessor to the new entry
                link_we    = 1'b1;
                link_waddr = prev_reg[AW-1:0];
                link_wdata = fresh_reg;
                state_next = S_RESP;
            end

            S_DUMP:
            begin
                if (out_free)
                begin
                    result_load    = 1'b1;
                    out_value_next = val_rdata;
                    status_next    = ST_OK;
                    last_next      = rd_link_null || (cnt_reg == DUMP_LAST);
                    if (last_next)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next  = cnt_reg + LW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = rd_link[AW-1:0];
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    result_load = 1'b1;
                    status_next = pend_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Mark a link entry as written
        if (link_we)
        begin
            lvalid_next[link_waddr] = 1'b1;
        end
    end

    // Output register: load, or drop once taken
    always_comb
    begin
        if (result_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            result_valid_next = result_valid_reg;
        end
        else
        begin
            result_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg         <= NULL_LINK;
            free_reg         <= '0;
            lvalid_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            free_reg         <= free_next;
            lvalid_reg       <= lvalid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        fresh_reg <= fresh_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        cnt_reg   <= cnt_next;
        key_reg   <= key_next;
        pend_reg  <= pend_next;
        if (ram_re)
        begin
            raddr_reg <= ram_raddr;
        end
        if (result_load)
        begin
            out_value_reg <= out_value_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_value    = out_value_reg;
    assign status       = status_reg;
    assign last_flag    = last_reg;

    // The list and the free chain never share their first slot
    a_head_free_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        !(!head_null && (head_reg == free_reg)))
        else $error("head and free list point at the same slot");

    // Clear empties the list and restores the reset chain
    a_clear_restores: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && (opcode == OP_CLEAR)) |=>
        (head_null && (free_reg == '0) && (lvalid_reg == '0)))
        else $error("clear did not restore the reset chain");

    // A full result is issued only with an empty free list
    a_full_needs_empty_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (result_load && (status_next == ST_FULL)) |-> free_null)
        else $error("full reported with a free slot left");

    // A completed insert links a freshly popped, non-null slot
    a_insert_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ins_done |-> ((fresh_reg < NULL_LINK) && (cnt_reg < NULL_LINK)))
        else $error("insert completed on a null slot or past the walk bound");

endmodule

/* rtl/slls_ram.sv */
`timescale 1ns / 1ps

module slls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
